// File: rtl/nine_bit_datagram_deframer_macros.svh
// assertion helpers for the datagram deframer checkers
`ifndef NINE_BIT_DATAGRAM_DEFRAMER_MACROS_SVH
`define NINE_BIT_DATAGRAM_DEFRAMER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define NBDD_ASSERT_HOLD(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NBDD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/nbdd_pkg.sv
package nbdd_pkg;

	localparam int MAX_FRAME_DEF = 18;

	localparam int BYTE_W    = 8;
	localparam int CHAR_W    = 9;
	localparam int LEN_W     = 5;
	localparam int MS_W      = 16;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;

	localparam logic [MS_W-1:0]  MS_MAX        = '1;
	localparam logic [CFG_W-1:0] IDLE_TIME_RST = 10'd10;
	localparam logic [CFG_W-1:0] SEND_GAP_RST  = 10'd10;
	localparam logic [LEN_W-1:0] LEN_BIAS      = 5'd3;
	localparam logic [LEN_W-1:0] MAX_LEN       = 5'd18;

	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_GAP  = 2'd1;

	localparam int CMDQ_DEPTH = 2;
	localparam int OUTQ_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_BYTE       = 2'd0,
		KIND_DROPPED    = 2'd1,
		KIND_UNEXPECTED = 2'd2,
		KIND_PERMIT     = 2'd3
	} kind_t;

	// work handed from the front to the back
	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  data;
		logic [LEN_W-1:0]   len;
	} cmd_t;

	// one result word
	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  data;
		logic               last;
		logic [LEN_W-1:0]   len;
	} res_t;

endpackage

// File: rtl/nbdd_ram.sv
module nbdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 18
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/nbdd_cmd_queue.sv
module nbdd_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nbdd_pkg::cmd_t din,
	output logic          full,
	output logic          valid,
	output nbdd_pkg::cmd_t dout,
	input  logic          pop
);

	localparam int DEPTH = nbdd_pkg::CMDQ_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	nbdd_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/nbdd_front.sv
module nbdd_front #(
	parameter int MAX_FRAME = nbdd_pkg::MAX_FRAME_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              func,
	input  logic [nbdd_pkg::CHAR_W-1:0]       char_in,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nbdd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nbdd_pkg::CFG_W-1:0]        cfg_data,
	output logic                              cmd_push,
	output nbdd_pkg::cmd_t                    cmd,
	input  logic                              cmdq_full,
	input  logic                              emit_done,
	output logic                              ram_we,
	output logic [$clog2(MAX_FRAME)-1:0]      ram_waddr,
	output logic [nbdd_pkg::BYTE_W-1:0]       ram_wdata
);

	localparam int AW    = $clog2(MAX_FRAME);
	localparam int LEN_W = nbdd_pkg::LEN_W;
	localparam int MS_W  = nbdd_pkg::MS_W;

	logic [nbdd_pkg::CFG_W-1:0] idle_time_q;
	logic [nbdd_pkg::CFG_W-1:0] send_gap_q;
	logic [LEN_W-1:0]           fill_q, fill_d;
	logic [LEN_W-1:0]           exp_q, exp_d;
	logic [MS_W-1:0]            since_in_q, since_in_d;
	logic [MS_W-1:0]            since_permit_q, since_permit_d;
	logic                       emit_busy_q, emit_busy_d;

	logic                       accept;
	logic [MS_W-1:0]            since_in_inc;
	logic [MS_W-1:0]            since_permit_inc;
	logic [LEN_W-1:0]           fill_inc;
	logic                       store_ok;

	// items wait while the command queue is full or the back still reads a finished datagram
	assign full      = cmdq_full || emit_busy_q;
	assign accept    = push && !full;
	assign cfg_ready = 1'b1;

	assign since_in_inc     = (since_in_q == nbdd_pkg::MS_MAX) ? since_in_q : since_in_q + 1'b1;
	assign since_permit_inc = (since_permit_q == nbdd_pkg::MS_MAX) ?
		since_permit_q : since_permit_q + 1'b1;
	assign fill_inc  = fill_q + 1'b1;
	assign store_ok  = {1'b0, fill_q} < (LEN_W + 1)'(MAX_FRAME);
	assign ram_wdata = char_in[nbdd_pkg::BYTE_W-1:0];

	always_comb begin
		fill_d         = fill_q;
		exp_d          = exp_q;
		since_in_d     = since_in_q;
		since_permit_d = since_permit_q;
		emit_busy_d    = emit_busy_q && !emit_done;
		cmd_push       = 1'b0;
		cmd            = '{kind: nbdd_pkg::KIND_PERMIT, data: '0, len: '0};
		ram_we         = 1'b0;
		ram_waddr      = fill_q[AW-1:0];
		if (accept) begin
			if (func) begin
				since_in_d     = since_in_inc;
				since_permit_d = since_permit_inc;
				if (since_in_inc >= MS_W'(idle_time_q) && since_permit_inc > MS_W'(send_gap_q)) begin
					cmd_push       = 1'b1;
					since_permit_d = '0;
				end
			end else begin
				since_in_d = '0;
				if (char_in[nbdd_pkg::CHAR_W-1]) begin
					if (fill_q != '0) begin
						cmd_push = 1'b1;
						cmd.kind = nbdd_pkg::KIND_DROPPED;
					end
					ram_we    = 1'b1;
					ram_waddr = '0;
					fill_d    = LEN_W'(1);
				end else if (fill_q == LEN_W'(1)) begin
					exp_d  = {1'b0, char_in[3:0]} + nbdd_pkg::LEN_BIAS;
					ram_we = store_ok;
					fill_d = fill_inc;
				end else if (fill_q < exp_q) begin
					ram_we = store_ok;
					if (fill_inc == exp_q) begin
						cmd_push    = 1'b1;
						cmd.kind    = nbdd_pkg::KIND_BYTE;
						cmd.len     = exp_q;
						fill_d      = '0;
						exp_d       = '0;
						emit_busy_d = 1'b1;
					end else begin
						fill_d = fill_inc;
					end
				end else begin
					cmd_push = 1'b1;
					cmd.kind = nbdd_pkg::KIND_UNEXPECTED;
					cmd.data = char_in[nbdd_pkg::BYTE_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q         <= '0;
			exp_q          <= '0;
			since_in_q     <= '0;
			since_permit_q <= '0;
			emit_busy_q    <= 1'b0;
		end else begin
			fill_q         <= fill_d;
			exp_q          <= exp_d;
			since_in_q     <= since_in_d;
			since_permit_q <= since_permit_d;
			emit_busy_q    <= emit_busy_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_time_q <= nbdd_pkg::IDLE_TIME_RST;
			send_gap_q  <= nbdd_pkg::SEND_GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				nbdd_pkg::REG_IDLE_TIME: idle_time_q <= cfg_data;
				nbdd_pkg::REG_SEND_GAP:  send_gap_q  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/nbdd_back.sv
module nbdd_back #(
	parameter int MAX_FRAME = nbdd_pkg::MAX_FRAME_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  nbdd_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	output logic                          emit_done,
	output logic                          ram_re,
	output logic [$clog2(MAX_FRAME)-1:0]  ram_raddr,
	input  logic [nbdd_pkg::BYTE_W-1:0]   ram_rdata,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    kind,
	output logic [nbdd_pkg::BYTE_W-1:0]   data_byte,
	output logic                          last,
	output logic [nbdd_pkg::LEN_W-1:0]    datagram_length
);

	localparam int AW    = $clog2(MAX_FRAME);
	localparam int LEN_W = nbdd_pkg::LEN_W;
	localparam int DEPTH = nbdd_pkg::OUTQ_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} back_state_t;

	back_state_t      state_q, state_d;
	logic [LEN_W-1:0] idx_q, idx_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] idx_inc;

	logic             valid_s1;
	logic             from_ram_s1;
	nbdd_pkg::res_t   res_s1;
	logic             load_s1;
	logic             load_from_ram;
	nbdd_pkg::res_t   load_res;

	nbdd_pkg::res_t   outq_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             can_issue;
	logic             do_pop;
	nbdd_pkg::res_t   push_res;
	nbdd_pkg::res_t   head;

	// a slot is reserved for the word sitting in the read stage
	assign can_issue = ((CW + 1)'(cnt_q) + (CW + 1)'(valid_s1)) < (CW + 1)'(DEPTH);
	assign idx_inc   = idx_q + 1'b1;
	assign ram_raddr = idx_q[AW-1:0];

	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		len_d         = len_q;
		cmd_pop       = 1'b0;
		emit_done     = 1'b0;
		ram_re        = 1'b0;
		load_s1       = 1'b0;
		load_from_ram = 1'b0;
		load_res      = '{kind: cmd.kind, data: cmd.data, last: 1'b1, len: '0};
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && can_issue) begin
					cmd_pop = 1'b1;
					if (cmd.kind == nbdd_pkg::KIND_BYTE) begin
						state_d = ST_EMIT;
						idx_d   = '0;
						len_d   = cmd.len;
					end else begin
						load_s1 = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				if (can_issue) begin
					ram_re        = 1'b1;
					load_s1       = 1'b1;
					load_from_ram = 1'b1;
					load_res      = '{kind: nbdd_pkg::KIND_BYTE, data: '0,
						last: (idx_inc == len_q), len: len_q};
					idx_d         = idx_inc;
					if (idx_inc == len_q) begin
						state_d   = ST_IDLE;
						emit_done = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			len_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			len_q    <= len_d;
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			res_s1      <= load_res;
			from_ram_s1 <= load_from_ram;
		end
	end

	// result queue
	always_comb begin
		push_res = res_s1;
		if (from_ram_s1) begin
			push_res.data = ram_rdata;
		end
	end

	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign head   = outq_q[rd_ptr_q];

	assign kind            = head.kind;
	assign data_byte       = head.data;
	assign last            = head.last;
	assign datagram_length = head.len;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			outq_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({valid_s1, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/nine_bit_datagram_deframer.sv
// Receives nine-bit bus characters and millisecond ticks through a queue-style input
// (push/full) and hands out result words through a queue-style output (empty/pop).
// The front takes one item per clock while its two-entry command queue has room and
// no datagram is being read back; a tick or a character gives at most one command.
// A completed datagram of L bytes (3 to 18) is read back from the frame memory by the
// back at one byte per clock while the result queue has room, and full is held high
// by a register set when the datagram completes until the back has issued the read
// of its last byte, since the next start character would overwrite that memory.
// Every result passes through the read-stage register into the result queue.
// The frame memory has no reset and needs no clearing pass; only bytes of the
// current datagram are ever read. The two timing registers are written through
// cfg_valid/cfg_ready, which is always ready.
module nine_bit_datagram_deframer #(
	parameter int MAX_FRAME = nbdd_pkg::MAX_FRAME_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           func,
	input  logic [nbdd_pkg::CHAR_W-1:0]    char_in,
	output logic                           empty,
	input  logic                           pop,
	output logic [1:0]                     kind,
	output logic [nbdd_pkg::BYTE_W-1:0]    data_byte,
	output logic                           last,
	output logic [nbdd_pkg::LEN_W-1:0]     datagram_length,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [nbdd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nbdd_pkg::CFG_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MAX_FRAME);

	nbdd_pkg::cmd_t               front_cmd;
	nbdd_pkg::cmd_t               back_cmd;
	logic                         cmd_push;
	logic                         cmdq_full;
	logic                         cmd_valid;
	logic                         cmd_pop;
	logic                         emit_done;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [nbdd_pkg::BYTE_W-1:0]  ram_wdata;
	logic                         ram_re;
	logic [AW-1:0]                ram_raddr;
	logic [nbdd_pkg::BYTE_W-1:0]  ram_rdata;

	nbdd_front #(.MAX_FRAME(MAX_FRAME)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.char_in   (char_in),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_push  (cmd_push),
		.cmd       (front_cmd),
		.cmdq_full (cmdq_full),
		.emit_done (emit_done),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	nbdd_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (front_cmd),
		.full   (cmdq_full),
		.valid  (cmd_valid),
		.dout   (back_cmd),
		.pop    (cmd_pop)
	);

	nbdd_ram #(
		.WIDTH (nbdd_pkg::BYTE_W),
		.DEPTH (MAX_FRAME)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	nbdd_back #(.MAX_FRAME(MAX_FRAME)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd             (back_cmd),
		.cmd_pop         (cmd_pop),
		.emit_done       (emit_done),
		.ram_re          (ram_re),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.empty           (empty),
		.pop             (pop),
		.kind            (kind),
		.data_byte       (data_byte),
		.last            (last),
		.datagram_length (datagram_length)
	);

endmodule

// File: rtl/nbdd_checker.sv
`include "nine_bit_datagram_deframer_macros.svh"

module nbdd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        empty,
	input logic                        pop,
	input logic [1:0]                  kind,
	input logic [nbdd_pkg::BYTE_W-1:0] data_byte,
	input logic                        last,
	input logic [nbdd_pkg::LEN_W-1:0]  datagram_length
);

	// a waiting word must hold until taken
	`NBDD_ASSERT_NEXT(a_word_held, !empty && !pop, !empty && $stable(kind) && $stable(data_byte) && $stable(last) && $stable(datagram_length), "waiting word changed")

	// status words stand alone
	`NBDD_ASSERT_HOLD(a_status_single, !empty && kind != nbdd_pkg::KIND_BYTE, last && datagram_length == '0, "status word not single")

	`NBDD_ASSERT_HOLD(a_len_range, !empty && kind == nbdd_pkg::KIND_BYTE, datagram_length >= nbdd_pkg::LEN_BIAS && datagram_length <= nbdd_pkg::MAX_LEN, "datagram length out of range")

	// bytes of one datagram come out back to back with one length
	`NBDD_ASSERT_NEXT(a_burst, !empty && pop && kind == nbdd_pkg::KIND_BYTE && !last, empty || (kind == nbdd_pkg::KIND_BYTE && $stable(datagram_length)), "datagram broken up")

	`NBDD_ASSERT_HOLD(a_zero_data, !empty && (kind == nbdd_pkg::KIND_DROPPED || kind == nbdd_pkg::KIND_PERMIT), data_byte == '0, "status word carries data")

endmodule

bind nine_bit_datagram_deframer nbdd_checker u_nbdd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.empty           (empty),
	.pop             (pop),
	.kind            (kind),
	.data_byte       (data_byte),
	.last            (last),
	.datagram_length (datagram_length)
);

// File: bench/nine_bit_datagram_deframer_tb.sv
`timescale 1ns / 1ps

module nine_bit_datagram_deframer_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 30;
	localparam int RESET_CYCLES   = 9;
	localparam logic [nbdd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           push = 1'b0;
	logic                           full;
	logic                           func = 1'b0;
	logic [nbdd_pkg::CHAR_W-1:0]    char_in = '0;
	logic                           empty;
	logic                           pop = 1'b0;
	logic [1:0]                     kind;
	logic [nbdd_pkg::BYTE_W-1:0]    data_byte;
	logic                           last;
	logic [nbdd_pkg::LEN_W-1:0]     datagram_length;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [nbdd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [nbdd_pkg::CFG_W-1:0]     cfg_data = '0;

	// mirror of the block state
	logic [nbdd_pkg::BYTE_W-1:0] frame_copy [nbdd_pkg::MAX_FRAME_DEF];
	logic [nbdd_pkg::LEN_W-1:0]  fill_cnt;
	logic [nbdd_pkg::LEN_W-1:0]  dgram_len;
	logic [nbdd_pkg::MS_W-1:0]   quiet_ms;
	logic [nbdd_pkg::MS_W-1:0]   permit_age_ms;
	logic [nbdd_pkg::CFG_W-1:0]  idle_req_ms;
	logic [nbdd_pkg::CFG_W-1:0]  gap_req_ms;

	nbdd_pkg::res_t due_words [$];
	int   errors = 0;
	int   items_sent = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   stalled_cycles = 0;

	nine_bit_datagram_deframer uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.func(func),
		.char_in(char_in),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.data_byte(data_byte),
		.last(last),
		.datagram_length(datagram_length),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic nbdd_pkg::res_t make_word(nbdd_pkg::kind_t k,
			logic [nbdd_pkg::BYTE_W-1:0] d, logic l, logic [nbdd_pkg::LEN_W-1:0] n);
		nbdd_pkg::res_t w;
		w.kind = k;
		w.data = d;
		w.last = l;
		w.len = n;
		return w;
	endfunction

	task automatic deframe_predict(input logic is_tick,
			input logic [nbdd_pkg::CHAR_W-1:0] ch);
		int i;
		if (is_tick) begin
			if (quiet_ms != nbdd_pkg::MS_MAX) quiet_ms++;
			if (permit_age_ms != nbdd_pkg::MS_MAX) permit_age_ms++;
			if (quiet_ms >= idle_req_ms && permit_age_ms > gap_req_ms) begin
				due_words.push_back(make_word(nbdd_pkg::KIND_PERMIT, '0, 1'b1, '0));
				permit_age_ms = '0;
			end
		end else begin
			quiet_ms = '0;
			if (ch[nbdd_pkg::CHAR_W-1]) begin
				// a new start abandons any partial datagram
				if (fill_cnt != 0)
					due_words.push_back(make_word(nbdd_pkg::KIND_DROPPED, '0, 1'b1, '0));
				frame_copy[0] = ch[nbdd_pkg::BYTE_W-1:0];
				fill_cnt = 1;
			end else if (fill_cnt == 1) begin
				dgram_len = ch[3:0] + nbdd_pkg::LEN_BIAS;
				frame_copy[1] = ch[nbdd_pkg::BYTE_W-1:0];
				fill_cnt = 2;
			end else if (fill_cnt < dgram_len) begin
				if (fill_cnt < nbdd_pkg::MAX_FRAME_DEF)
					frame_copy[fill_cnt] = ch[nbdd_pkg::BYTE_W-1:0];
				fill_cnt++;
				if (fill_cnt == dgram_len) begin
					for (i = 0; i < dgram_len; i++)
						due_words.push_back(make_word(nbdd_pkg::KIND_BYTE, frame_copy[i],
							i == int'(dgram_len) - 1, dgram_len));
					fill_cnt = '0;
					dgram_len = '0;
				end
			end else begin
				due_words.push_back(make_word(nbdd_pkg::KIND_UNEXPECTED,
					ch[nbdd_pkg::BYTE_W-1:0], 1'b1, '0));
			end
		end
	endtask

	function automatic void check_field(string name, int want_v, int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_words
		nbdd_pkg::res_t want;
		if (arst_n && pop && !empty) begin
			if (due_words.size() == 0) begin
				$display("%0t: word with none expected, expected none, actual %0h %0h %0h %0h",
					$time, kind, data_byte, last, datagram_length);
				errors++;
			end else begin
				want = due_words.pop_front();
				check_field("kind", want.kind, kind);
				check_field("data_byte", want.data, data_byte);
				check_field("last", want.last, last);
				check_field("datagram_length", want.len, datagram_length);
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			stalled_cycles <= 0;
		end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
		end
	end

	task automatic send_item(input logic is_tick, input logic [nbdd_pkg::CHAR_W-1:0] ch);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		func <= is_tick;
		char_in <= ch;
		do @(posedge clk); while (full);
		items_sent++;
		deframe_predict(is_tick, ch);
	endtask

	// let every expected word out, then give silent items time to settle
	task automatic drain;
		@(negedge clk);
		push <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [nbdd_pkg::CFG_IDX_W-1:0] idx,
			input logic [nbdd_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			nbdd_pkg::REG_IDLE_TIME: idle_req_ms = val;
			nbdd_pkg::REG_SEND_GAP: gap_req_ms = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_datagram(input bit cut_short);
		int body;
		int n;
		body = ($urandom_range(9) == 0) ? 15 : $urandom_range(4);
		n = body + 3;
		if (cut_short) n = $urandom_range(1, n - 1);
		send_item(1'b0, {1'b1, 8'($urandom)});
		for (int i = 1; i < n; i++) begin
			if ($urandom_range(9) < 2) send_item(1'b1, 9'($urandom));
			if (i == 1)
				send_item(1'b0, {1'b0, 4'($urandom), 4'(body)});
			else
				send_item(1'b0, {1'b0, 8'($urandom)});
		end
	endtask

	task automatic test_framing;
		send_item(1'b0, 9'h0aa);
		// shortest datagram, extreme byte values
		send_item(1'b0, 9'h100);
		send_item(1'b0, 9'h000);
		send_item(1'b0, 9'h0ff);
		// partial datagram cut off by the next start
		send_item(1'b0, 9'h1c3);
		send_item(1'b0, 9'h041);
		// longest datagram
		send_item(1'b0, 9'h1ff);
		send_item(1'b0, 9'h08f);
		repeat (16) send_item(1'b0, {1'b0, 8'($urandom)});
		send_item(1'b0, 9'h055);
		drain;
	endtask

	task automatic test_register_extremes;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain;
		write_reg(nbdd_pkg::REG_IDLE_TIME, '0);
		write_reg(nbdd_pkg::REG_SEND_GAP, '0);
		write_reg(REG_UNUSED, '1);
		// zero idle time: permit on every tick, never on a character
		send_item(1'b1, '1);
		send_item(1'b1, '0);
		send_item(1'b0, 9'h07e);
		send_item(1'b1, 9'h155);
		drain;
	endtask

	task automatic test_random_traffic(input int n_items, input int send_idle,
			input int recv_stall, input bit set_regs, input int idle_v, input int gap_v);
		int r;
		int target;
		send_idle_pct = send_idle;
		recv_stall_pct = recv_stall;
		if (set_regs) begin
			write_reg(nbdd_pkg::REG_IDLE_TIME, nbdd_pkg::CFG_W'(idle_v));
			write_reg(nbdd_pkg::REG_SEND_GAP, nbdd_pkg::CFG_W'(gap_v));
		end
		target = items_sent + n_items;
		while (items_sent < target) begin
			r = $urandom_range(99);
			if (r < 55)
				send_datagram(1'b0);
			else if (r < 65)
				send_datagram(1'b1);
			else if (r < 85)
				repeat ($urandom_range(1, 12)) send_item(1'b1, 9'($urandom));
			else if (r < 93)
				send_item(1'b0, {1'b0, 8'($urandom)});
			else
				send_item(1'b0, 9'($urandom));
		end
		drain;
	endtask

	initial begin
		fill_cnt = '0;
		dgram_len = '0;
		quiet_ms = '0;
		permit_age_ms = '0;
		idle_req_ms = nbdd_pkg::IDLE_TIME_RST;
		gap_req_ms = nbdd_pkg::SEND_GAP_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_framing;
		test_random_traffic(45, 0, 0, 1'b0, 0, 0);
		test_register_extremes;
		test_random_traffic(40, 84, 0, 1'b1, 1, 0);
		test_random_traffic(40, 0, 84, 1'b1, 0, 5);
		test_random_traffic(40, 15, 15, 1'b1, $urandom_range(1, 12), $urandom_range(0, 12));

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
